// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checks clocked on clk and held off while rst is high

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int DB_W      = 11;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int LIMIT_W   = 20;
  localparam int CUR_W     = 21;

  // averaging window, length must be a power of two
  localparam int WINDOW_LEN = 8;
  localparam int WIN_SHIFT  = $clog2(WINDOW_LEN);
  localparam int Q_W        = CUR_W - WIN_SHIFT;

  // consecutive overcurrent samples before a trip
  localparam int TRIP_COUNT = 50;
  localparam int CNT_W      = $clog2(TRIP_COUNT + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] zero_offset;
    logic [DB_W-1:0]            dead_band;
    logic [GAIN_W-1:0]          gain;
    logic [LIMIT_W-1:0]         current_limit;
  } cfg_t;

  // filter and trip outcome of one sample
  typedef struct packed {
    logic signed [CUR_W-1:0] filt;
    logic                    trip;
    logic                    flag;
  } win_res_t;

endpackage

`default_nettype wire

// ===== sv/csf_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csf_scale (
  input  wire logic signed [csf_pkg::SAMPLE_W-1:0] sample,
  input  wire csf_pkg::cfg_t                       cfg,
  output logic signed [csf_pkg::CUR_W-1:0]         current_now
);
  import csf_pkg::*;

  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] db_s;
  logic signed [SAMPLE_W:0] cored;
  logic signed [SAMPLE_W:0] abs_cored;
  logic                     neg;
  logic [SAMPLE_W-1:0]      mag;
  logic [SAMPLE_W+GAIN_W-1:0] prod;
  logic [CUR_W-2:0]         scaled;

  always_comb begin
    diff = {sample[SAMPLE_W-1], sample} - {cfg.zero_offset[SAMPLE_W-1], cfg.zero_offset};
    db_s = signed'({{(SAMPLE_W + 1 - DB_W){1'b0}}, cfg.dead_band});

    // deadband pulls toward zero
    if (diff > db_s) begin
      cored = diff - db_s;
    end else if (diff < -db_s) begin
      cored = diff + db_s;
    end else begin
      cored = '0;
    end

    neg       = cored[SAMPLE_W];
    abs_cored = neg ? -cored : cored;
    mag       = abs_cored[SAMPLE_W-1:0];

    // q8.8 gain on the magnitude, fraction dropped
    prod   = mag * cfg.gain;
    scaled = prod[GAIN_FRAC +: CUR_W-1];

    current_now = neg ? -signed'({1'b0, scaled}) : signed'({1'b0, scaled});
  end

endmodule

`default_nettype wire

// ===== sv/csf_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csf_window (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         upd,
  input  wire logic signed [csf_pkg::CUR_W-1:0] current_now,
  input  wire logic [csf_pkg::LIMIT_W-1:0]  current_limit,
  output csf_pkg::win_res_t                 res
);
  import csf_pkg::*;

  // window holds truncated eighths, sum is their running total
  logic signed [Q_W-1:0]   quot [WINDOW_LEN];
  logic signed [CUR_W-1:0] sum;
  logic [CNT_W-1:0]        over_count;
  logic                    sticky_over;

  logic signed [CUR_W-1:0] biased;
  logic signed [CUR_W-1:0] q_full;
  logic signed [Q_W-1:0]   q_new;
  logic signed [CUR_W-1:0] sum_next;
  logic [CUR_W-1:0]        filt_mag;
  logic                    over;
  logic [CNT_W-1:0]        over_count_next;
  logic                    sticky_over_next;
  logic                    trip_next;

  always_comb begin
    // divide toward zero: bias negatives before the shift
    biased   = current_now +
               signed'({{(CUR_W - WIN_SHIFT){1'b0}}, {WIN_SHIFT{current_now[CUR_W-1]}}});
    q_full   = biased >>> WIN_SHIFT;
    q_new    = q_full[Q_W-1:0];
    sum_next = sum + {{WIN_SHIFT{q_new[Q_W-1]}}, q_new}
                   - {{WIN_SHIFT{quot[0][Q_W-1]}}, quot[0]};

    filt_mag = sum_next[CUR_W-1] ? unsigned'(-sum_next) : unsigned'(sum_next);
    over     = filt_mag > {1'b0, current_limit};

    over_count_next  = over_count;
    sticky_over_next = sticky_over;
    trip_next        = 1'b0;
    if (current_limit != '0) begin
      over_count_next = over ? over_count + 1'b1 : '0;
      if (over_count_next == CNT_W'(TRIP_COUNT)) begin
        trip_next        = 1'b1;
        sticky_over_next = 1'b1;
        over_count_next  = '0;
      end
    end

    res.filt = sum_next;
    res.trip = trip_next;
    res.flag = sticky_over_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        quot[i] <= '0;
      end
      sum         <= '0;
      over_count  <= '0;
      sticky_over <= 1'b0;
    end else if (upd) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        quot[i] <= quot[i+1];
      end
      quot[WINDOW_LEN-1] <= q_new;
      sum         <= sum_next;
      over_count  <= over_count_next;
      sticky_over <= sticky_over_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/current_sense_filter_overcurrent_trip_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// motor current sense filter with overcurrent trip
// input channel: in_valid/in_ready with one signed 12-bit adc sample per transfer
// output channel: out_valid/out_ready with the scaled current, the 8-sample
// average, a one-shot trip bit and the sticky overcurrent flag
// config channel: cfg_valid/cfg_ready, cfg_index picks zero_offset, dead_band,
// gain or current_limit; cfg_ready is always high, write only while idle
// pipeline: input register, scale stage (offset, deadband, 12x16 multiply),
// then the window update into the output register
// path: a sample accepted into the input register moves on to the scaled current
// register and then to the output register, where out_valid presents it
// throughput: one sample per cycle while out_ready does not hold the output, as
// the window keeps a running sum (add newest eighth, drop oldest)
// stall: each stage holds while the next one is full and stalled; bubbles
// still fill, so in_ready drops only once all three stages hold data
// reset: window, running sum, trip counter and sticky flag clear, registers
// return to offset 0, deadband 0, gain 1.0, limit 0 (checking off)
module current_sense_filter_overcurrent_trip_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [csf_pkg::SAMPLE_W-1:0] sample,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [csf_pkg::CUR_W-1:0]       current_now,
  output logic signed [csf_pkg::CUR_W-1:0]       current_filtered,
  output logic                                   trip,
  output logic                                   overcurrent_flag,
  // register write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [csf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [csf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import csf_pkg::*;

  cfg_t cfg;

  // stage 1: captured sample
  logic                       v1;
  logic signed [SAMPLE_W-1:0] sample_q;
  // stage 2: scaled current
  logic                       v2;
  logic signed [CUR_W-1:0]    now_q;

  logic signed [CUR_W-1:0]    now_comb;
  win_res_t                   res;

  logic adv1;
  logic adv2;
  logic adv3;
  logic upd;

  // each stage moves when its successor is empty or moving
  assign adv3     = !out_valid || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign upd      = v2 && adv3;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_offset   <= '0;
      cfg.dead_band     <= '0;
      cfg.gain          <= GAIN_W'(256);
      cfg.current_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZERO_OFFSET:   cfg.zero_offset   <= cfg_data[SAMPLE_W-1:0];
        REG_DEAD_BAND:     cfg.dead_band     <= cfg_data[DB_W-1:0];
        REG_GAIN:          cfg.gain          <= cfg_data[GAIN_W-1:0];
        REG_CURRENT_LIMIT: cfg.current_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (in_valid && adv1) begin
      sample_q <= sample;
    end
  end

  csf_scale u_scale (
    .sample      (sample_q),
    .cfg         (cfg),
    .current_now (now_comb)
  );

  // scaled current register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (v1 && adv2) begin
      now_q <= now_comb;
    end
  end

  csf_window u_window (
    .clk           (clk),
    .rst           (rst),
    .upd           (upd),
    .current_now   (now_q),
    .current_limit (cfg.current_limit),
    .res           (res)
  );

  // output register, loaded together with the window update
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      overcurrent_flag <= 1'b0;
      trip             <= 1'b0;
    end else begin
      if (adv3) begin
        out_valid <= v2;
      end
      if (upd) begin
        trip             <= res.trip;
        overcurrent_flag <= res.flag;
      end
    end
    if (upd) begin
      current_now      <= now_q;
      current_filtered <= res.filt;
    end
  end

  // a trip always shows the flag set
  `ASSERT_IMPLIES(a_trip_sets_flag, out_valid && trip, overcurrent_flag, "trip without flag")
  // no trip while checking is disabled
  `ASSERT_IMPLIES(a_trip_needs_limit, upd && res.trip, cfg.current_limit != '0, "trip with limit zero")
  // the flag stays set until reset
  `ASSERT_IMPLIES(a_flag_sticky, !$past(rst) && $past(overcurrent_flag), overcurrent_flag, "flag cleared")
  // a stalled result keeps its window outcome
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, $stable(current_filtered) && $stable(trip), "result changed under stall")

endmodule

`default_nettype wire
